FILE: rtl/core/nsfa_pkg.sv
// Shared types and constants for the neighbor spring force accumulator.
// Used by the front end, the queue, the back end and the top level.
package nsfa_pkg;

  localparam int unsigned POS_W       = 32;
  localparam int unsigned REST_W      = 31;
  localparam int unsigned ACC_W       = 40;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACTION  = 1'b1;

  // One classified neighbor record as it travels through the queue.
  typedef struct packed {
    logic signed [POS_W-1:0]  ux;
    logic signed [POS_W-1:0]  uy;
    logic signed [POS_W-1:0]  uz;
    logic        [REST_W-1:0] rest;
    logic                     knots;     // both cells are knots
    logic                     interior;
    logic                     add;       // record contributes a term
    logic                     last;      // record closes the cell
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: rtl/core/neighbor_spring_force_accumulator_top.sv
// Neighbor spring force accumulator, top level: configuration registers,
// front end, record queue and back end. Depends on nsfa_pkg.
//
// Usage. Neighbor records enter on the in_ channel (valid/ready), one per
// transaction; the record with in_last_slot set closes a cell, and one
// result (delta_x/y/z) leaves on the out_ channel per closed cell.
// Registers are written through cfg_wr_en/cfg_index/cfg_wdata while the
// block is idle: index 0 is the stiffness, index 1 the traction gain.
// Timing. Records are handled one at a time. A spring record holds the back
// end while it is popped, its offsets squared on the shared multiplier, the
// root taken, the record classified, spring products formed, the dividers
// run and the sum updated. A traction record has gain products instead of
// spring products and division; a live record adding nothing ends after
// classification. Closing a cell adds output scaling on the same multiplier
// and the output register load; a dead last slot goes straight to scaling.
// Dead slots not marked last are dropped in the front end and cost nothing.
// A four-entry queue lets the input keep taking records while the back end
// works or while a result waits in the output register. If the receiver
// stalls, the back end holds its next result and the queue fills, then
// in_ready drops. Reset clears the sums, the registers, the queue and output.
module neighbor_spring_force_accumulator_top #(
  parameter int unsigned FRAC_BITS = nsfa_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [nsfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nsfa_pkg::POS_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_self_x,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_self_y,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_self_z,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_other_x,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_other_y,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_other_z,
  input  logic        [nsfa_pkg::REST_W-1:0]  in_rest_length,
  input  logic                                in_self_knot,
  input  logic                                in_other_knot,
  input  logic                                in_self_interior,
  input  logic                                in_slot_valid,
  input  logic                                in_last_slot,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [nsfa_pkg::POS_W-1:0]   out_delta_x,
  output logic signed [nsfa_pkg::POS_W-1:0]   out_delta_y,
  output logic signed [nsfa_pkg::POS_W-1:0]   out_delta_z
);
  import nsfa_pkg::*;

  logic signed [POS_W-1:0] stiffness_r;
  logic signed [POS_W-1:0] traction_r;
  logic                    push;
  logic                    pop;
  entry_t                  push_entry;
  entry_t                  head;
  queue_status_t           q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r <= '0;
      traction_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STIFFNESS: stiffness_r <= cfg_wdata;
        REG_TRACTION:  traction_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  nsfa_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_self_x        (in_self_x),
    .in_self_y        (in_self_y),
    .in_self_z        (in_self_z),
    .in_other_x       (in_other_x),
    .in_other_y       (in_other_y),
    .in_other_z       (in_other_z),
    .in_rest_length   (in_rest_length),
    .in_self_knot     (in_self_knot),
    .in_other_knot    (in_other_knot),
    .in_self_interior (in_self_interior),
    .in_slot_valid    (in_slot_valid),
    .in_last_slot     (in_last_slot),
    .q_status         (q_status),
    .push             (push),
    .push_entry       (push_entry)
  );

  nsfa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  nsfa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .head          (head),
    .pop           (pop),
    .stiffness     (stiffness_r),
    .traction_gain (traction_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_delta_x   (out_delta_x),
    .out_delta_y   (out_delta_y),
    .out_delta_z   (out_delta_z)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !push)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.empty |-> !pop)
    else $error("queue read while empty");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");
`endif

endmodule

FILE: rtl/core/nsfa_front.sv
// Front end: takes neighbor records, forms the saturated offsets and
// classifies each record. Depends on nsfa_pkg.
module nsfa_front (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_self_x,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_self_y,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_self_z,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_other_x,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_other_y,
  input  logic signed [nsfa_pkg::POS_W-1:0]   in_other_z,
  input  logic        [nsfa_pkg::REST_W-1:0]  in_rest_length,
  input  logic                                in_self_knot,
  input  logic                                in_other_knot,
  input  logic                                in_self_interior,
  input  logic                                in_slot_valid,
  input  logic                                in_last_slot,
  input  nsfa_pkg::queue_status_t             q_status,
  output logic                                push,
  output nsfa_pkg::entry_t                    push_entry
);
  import nsfa_pkg::*;

  function automatic logic signed [POS_W-1:0] sat_offset(
    input logic signed [POS_W-1:0] a,
    input logic signed [POS_W-1:0] b
  );
    logic signed [POS_W:0] diff;
    diff = {b[POS_W-1], b} - {a[POS_W-1], a};
    if (diff[POS_W] != diff[POS_W-1]) begin
      sat_offset = diff[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_offset = diff[POS_W-1:0];
    end
  endfunction

  assign in_ready = !q_status.full;

  // A dead slot that does not close the cell has no effect and is dropped here.
  assign push = in_valid && in_ready && (in_slot_valid || in_last_slot);

  always_comb begin
    push_entry.ux       = sat_offset(in_self_x, in_other_x);
    push_entry.uy       = sat_offset(in_self_y, in_other_y);
    push_entry.uz       = sat_offset(in_self_z, in_other_z);
    push_entry.rest     = in_rest_length;
    push_entry.knots    = in_self_knot && in_other_knot;
    push_entry.interior = in_self_interior;
    push_entry.add      = in_slot_valid;
    push_entry.last     = in_last_slot;
  end

endmodule

FILE: rtl/core/nsfa_queue.sv
// Short queue of classified records between the front and back ends.
// Depends on nsfa_pkg.
module nsfa_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  nsfa_pkg::entry_t        push_entry,
  input  logic                    pop,
  output nsfa_pkg::entry_t        head,
  output nsfa_pkg::queue_status_t status
);
  import nsfa_pkg::*;

  entry_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign status.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/core/nsfa_back.sv
// Back end: sequencer around one shared 32x32 multiplier, a bit-serial
// square root and three bit-serial dividers; holds the sums and the output
// register. Depends on nsfa_pkg.
module nsfa_back #(
  parameter int unsigned FRAC_BITS = nsfa_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nsfa_pkg::queue_status_t            q_status,
  input  nsfa_pkg::entry_t                   head,
  output logic                               pop,
  input  logic signed [nsfa_pkg::POS_W-1:0]  stiffness,
  input  logic signed [nsfa_pkg::POS_W-1:0]  traction_gain,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [nsfa_pkg::POS_W-1:0]  out_delta_x,
  output logic signed [nsfa_pkg::POS_W-1:0]  out_delta_y,
  output logic signed [nsfa_pkg::POS_W-1:0]  out_delta_z
);
  import nsfa_pkg::*;

  localparam int unsigned QW = ACC_W;  // quotient bits kept
  localparam int unsigned PW = 2 * POS_W;
  localparam int unsigned SW = PW + 8;  // scaled product width

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_SQ    = 10'b00_0000_0010,
    ST_ROOT  = 10'b00_0000_0100,
    ST_CLASS = 10'b00_0000_1000,
    ST_SMUL  = 10'b00_0001_0000,
    ST_DIV   = 10'b00_0010_0000,
    ST_GMUL  = 10'b00_0100_0000,
    ST_ACC   = 10'b00_1000_0000,
    ST_SCALE = 10'b01_0000_0000,
    ST_OUT   = 10'b10_0000_0000
  } state_t;

  function automatic logic signed [ACC_W-1:0] sat_term(input logic [PW-1:0] m,
                                                       input logic neg);
    logic [PW-1:0] lim;
    lim = PW'(1) << (ACC_W - 1);
    if (neg) begin
      sat_term = (m > lim) ? {1'b1, {(ACC_W-1){1'b0}}} : ACC_W'(-m);
    end else begin
      sat_term = (m > lim - 1'b1) ? {1'b0, {(ACC_W-1){1'b1}}} : m[ACC_W-1:0];
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] add_sat(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      add_sat = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      add_sat = s[ACC_W-1:0];
    end
  endfunction

  function automatic logic [POS_W-1:0] mag32(input logic signed [POS_W-1:0] v);
    mag32 = v[POS_W-1] ? POS_W'(-v) : v;
  endfunction

  state_t                   state_r, state_nxt;
  logic [5:0]               cnt_r;
  entry_t                   cur_r;
  logic [POS_W-1:0]         umag_r [3];
  logic                     uneg_r [3];
  logic [PW-1:0]            sumsq_r;
  logic [PW-1:0]            xs_r;
  logic [POS_W+3:0]         rem_r;
  logic [POS_W-1:0]         root_r;
  logic [POS_W-1:0]         emag_r;
  logic                     eneg_r;
  logic                     spring_r;
  logic [POS_W-1:0]         drem_r [3];
  logic [QW-1:0]            dq_r [3];
  logic                     ovf_r [3];
  logic [PW-1:0]            tmag_r [3];
  logic                     tneg_r [3];
  logic signed [ACC_W-1:0]  sum_r [3];
  logic [PW-1:0]            prod_r;
  logic [SW-1:0]            sacc_r;
  logic [POS_W-1:0]         res_r [3];
  logic                     out_valid_r;
  logic signed [POS_W-1:0]  out_x_r, out_y_r, out_z_r;

  logic [POS_W-1:0]         mul_a, mul_b;
  logic [1:0]               lane;
  logic [1:0]               prev_lane;
  logic [1:0]               scale_lane;
  logic signed [POS_W-1:0]  clamp_c;
  logic [POS_W-1:0]         cmag, gmag;
  logic [ACC_W-1:0]         smag [3];
  logic [POS_W+3:0]         rem_try, root_try;
  logic [POS_W:0]           d_ext, rest_ext;
  logic                     load_out;

  assign lane       = cnt_r[1:0];
  assign prev_lane  = 2'(cnt_r - 6'd1);
  assign scale_lane = 2'((cnt_r - 6'd1) >> 1);
  assign clamp_c    = (stiffness > (POS_W'(1) << FRAC_BITS)) ?
                      (POS_W'(1) << FRAC_BITS) : stiffness;
  assign cmag       = mag32(clamp_c);
  assign gmag       = mag32(traction_gain);
  assign d_ext      = {1'b0, root_r};
  assign rest_ext   = {2'b00, cur_r.rest};
  assign rem_try    = {rem_r[POS_W+1:0], xs_r[PW-1:PW-2]};
  assign root_try   = {2'b00, root_r, 2'b01};
  assign load_out   = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  for (genvar l = 0; l < 3; l++) begin : g_smag
    assign smag[l] = sum_r[l][ACC_W-1] ? ACC_W'(-sum_r[l]) : sum_r[l];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        if (cnt_r < 6'd3) begin
          mul_a = umag_r[lane];
          mul_b = umag_r[lane];
        end
      end
      ST_SMUL: begin
        if (cnt_r < 6'd3) begin
          mul_a = umag_r[lane];
          mul_b = emag_r;
        end
      end
      ST_GMUL: begin
        if (cnt_r < 6'd3) begin
          mul_a = umag_r[lane];
          mul_b = gmag;
        end
      end
      ST_SCALE: begin
        if (cnt_r < 6'd6) begin
          mul_a = cnt_r[0] ? {24'd0, smag[cnt_r[2:1]][ACC_W-1:POS_W]}
                           : smag[cnt_r[2:1]][POS_W-1:0];
          mul_b = cmag;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          state_nxt = head.add ? ST_SQ : ST_SCALE;
        end
      end
      ST_SQ:    if (cnt_r == 6'd3) state_nxt = ST_ROOT;
      ST_ROOT:  if (cnt_r == 6'd31) state_nxt = ST_CLASS;
      ST_CLASS: begin
        if (cur_r.knots || (d_ext < rest_ext)) begin
          if (root_r != '0) begin
            state_nxt = ST_SMUL;
          end else begin
            state_nxt = cur_r.last ? ST_SCALE : ST_IDLE;
          end
        end else if (cur_r.interior) begin
          state_nxt = ST_GMUL;
        end else begin
          state_nxt = cur_r.last ? ST_SCALE : ST_IDLE;
        end
      end
      ST_SMUL:  if (cnt_r == 6'd3) state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == 6'(QW - 1)) state_nxt = ST_ACC;
      ST_GMUL:  if (cnt_r == 6'd3) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = cur_r.last ? ST_SCALE : ST_IDLE;
      ST_SCALE: if (cnt_r == 6'd6) state_nxt = ST_OUT;
      ST_OUT:   if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < 3; l++) begin
        sum_r[l] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? 6'd0 : cnt_r + 6'd1;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_ACC) begin
        for (int l = 0; l < 3; l++) begin
          sum_r[l] <= add_sat(sum_r[l], sat_term(spring_r ?
                      (ovf_r[l] ? '1 : PW'(dq_r[l])) : tmag_r[l], tneg_r[l]));
        end
      end
      if (load_out) begin
        for (int l = 0; l < 3; l++) begin
          sum_r[l] <= '0;
        end
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    logic [SW-1:0] full;
    logic [SW-1:0] q;
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        cur_r     <= head;
        umag_r[0] <= mag32(head.ux);
        umag_r[1] <= mag32(head.uy);
        umag_r[2] <= mag32(head.uz);
        uneg_r[0] <= head.ux[POS_W-1];
        uneg_r[1] <= head.uy[POS_W-1];
        uneg_r[2] <= head.uz[POS_W-1];
        sumsq_r   <= '0;
      end
      ST_SQ: begin
        if (cnt_r != 6'd0) begin
          sumsq_r <= sumsq_r + prod_r;
        end
        xs_r   <= sumsq_r + prod_r;
        rem_r  <= '0;
        root_r <= '0;
      end
      ST_ROOT: begin
        // One root bit per cycle, two radicand bits shifted in.
        xs_r <= {xs_r[PW-3:0], 2'b00};
        if (rem_try >= root_try) begin
          rem_r  <= rem_try - root_try;
          root_r <= {root_r[POS_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_try;
          root_r <= {root_r[POS_W-2:0], 1'b0};
        end
      end
      ST_CLASS: begin
        spring_r <= cur_r.knots || (d_ext < rest_ext);
        eneg_r   <= d_ext < rest_ext;
        emag_r   <= (d_ext < rest_ext) ? POS_W'(rest_ext - d_ext) : POS_W'(d_ext - rest_ext);
      end
      ST_SMUL: begin
        if (cnt_r != 6'd0) begin
          drem_r[prev_lane] <= {8'd0, prod_r[PW-1:QW]};
          dq_r[prev_lane]   <= prod_r[QW-1:0];
          ovf_r[prev_lane]  <= {8'd0, prod_r[PW-1:QW]} >= root_r;
          tneg_r[prev_lane] <= uneg_r[prev_lane] ^ eneg_r;
        end
      end
      ST_DIV: begin
        for (int l = 0; l < 3; l++) begin
          if ({drem_r[l], dq_r[l][QW-1]} >= {1'b0, root_r}) begin
            drem_r[l] <= POS_W'({drem_r[l], dq_r[l][QW-1]} - {1'b0, root_r});
            dq_r[l]   <= {dq_r[l][QW-2:0], 1'b1};
          end else begin
            drem_r[l] <= {drem_r[l][POS_W-2:0], dq_r[l][QW-1]};
            dq_r[l]   <= {dq_r[l][QW-2:0], 1'b0};
          end
        end
      end
      ST_GMUL: begin
        if (cnt_r != 6'd0) begin
          tmag_r[prev_lane] <= prod_r >> FRAC_BITS;
          tneg_r[prev_lane] <= uneg_r[prev_lane] ^ traction_gain[POS_W-1];
        end
      end
      ST_SCALE: begin
        if (cnt_r != 6'd0) begin
          if (prev_lane[0] == 1'b0) begin
            sacc_r <= SW'(prod_r);
          end else begin
            full = sacc_r + {prod_r[ACC_W-1:0], {POS_W{1'b0}}};
            q    = full >> FRAC_BITS;
            if (sum_r[scale_lane][ACC_W-1] != clamp_c[POS_W-1]) begin
              res_r[scale_lane] <= (q > SW'(33'h1_0000_0000 >> 1)) ?
                  {1'b1, {(POS_W-1){1'b0}}} : POS_W'(-q);
            end else begin
              res_r[scale_lane] <= (q > SW'({1'b0, {(POS_W-1){1'b1}}})) ?
                  {1'b0, {(POS_W-1){1'b1}}} : q[POS_W-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_x_r <= res_r[0];
      out_y_r <= res_r[1];
      out_z_r <= res_r[2];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_delta_x = out_x_r;
  assign out_delta_y = out_y_r;
  assign out_delta_z = out_z_r;

endmodule

FILE: sim/neighbor_spring_force_accumulator_top_test.sv
// Self-checking testbench for neighbor_spring_force_accumulator_top.
// Holds its own force predictor, drives random handshake gaps on both channels.
// Depends on nsfa_pkg and the top level of the block.
module neighbor_spring_force_accumulator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nsfa_pkg::*;

  localparam int FRAC = 16;
  localparam longint SUM_MAX = 64'sd549755813887;
  localparam longint SUM_MIN = -64'sd549755813888;

  typedef struct {
    logic signed [POS_W-1:0] sx, sy, sz, ox, oy, oz;
    logic [REST_W-1:0] rest;
    bit sk, ok, interior, live, last;
  } neighbor_rec_t;

  typedef struct {
    logic signed [POS_W-1:0] dx, dy, dz;
  } force_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [POS_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [POS_W-1:0] in_self_x = 0, in_self_y = 0, in_self_z = 0;
  logic signed [POS_W-1:0] in_other_x = 0, in_other_y = 0, in_other_z = 0;
  logic [REST_W-1:0] in_rest_length = 0;
  logic in_self_knot = 0, in_other_knot = 0, in_self_interior = 0;
  logic in_slot_valid = 0, in_last_slot = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [POS_W-1:0] out_delta_x, out_delta_y, out_delta_z;

  neighbor_spring_force_accumulator_top dut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  longint stiff_reg = 0, pull_reg = 0;
  longint acc_x = 0, acc_y = 0, acc_z = 0;
  force_t pending_forces[$];
  int errors = 0;
  int forces_checked = 0;
  int records_sent = 0;
  bit no_gaps = 0;
  int out_stall = 0;

  function automatic longint unsigned magn(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint sat_sum(longint unsigned m, bit neg);
    if (neg) return m > 64'd549755813888 ? SUM_MIN : -longint'(m);
    return m > 64'd549755813887 ? SUM_MAX : longint'(m);
  endfunction

  function automatic longint add_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint offset_of(logic signed [POS_W-1:0] a, logic signed [POS_W-1:0] b);
    longint u;
    u = longint'(b) - longint'(a);
    if (u > 64'sd2147483647) u = 64'sd2147483647;
    if (u < -64'sd2147483648) u = -64'sd2147483648;
    return u;
  endfunction

  function automatic longint spring(longint u, longint e, longint unsigned d);
    return sat_sum(magn(u) * magn(e) / d, (u < 0) != (e < 0));
  endfunction

  function automatic longint pull(longint u, longint g);
    return sat_sum((magn(u) * magn(g)) >> FRAC, (u < 0) != (g < 0));
  endfunction

  function automatic logic [POS_W-1:0] scaled(longint s, longint c);
    longint unsigned a, b, p, bound;
    bit neg;
    a = magn(s);
    b = magn(c);
    neg = (s < 0) != (c < 0);
    bound = 64'd1 << (32 + FRAC);
    if (b != 0 && a > (bound - 1) / b) p = bound;
    else p = (a * b) >> FRAC;
    if (neg) begin
      if (p > 64'd2147483648) p = 64'd2147483648;
      return POS_W'(64'd0 - p);
    end
    if (p > 64'd2147483647) p = 64'd2147483647;
    return POS_W'(p);
  endfunction

  task automatic predict_force(neighbor_rec_t r);
    longint ux, uy, uz, e, c;
    longint unsigned d;
    force_t f;
    if (r.live) begin
      ux = offset_of(r.sx, r.ox);
      uy = offset_of(r.sy, r.oy);
      uz = offset_of(r.sz, r.oz);
      d = int_sqrt(magn(ux) * magn(ux) + magn(uy) * magn(uy) + magn(uz) * magn(uz));
      if ((r.sk && r.ok) || longint'(d) < longint'(r.rest)) begin
        if (d > 0) begin
          e = longint'(d) - longint'(r.rest);
          acc_x = add_sum(acc_x, spring(ux, e, d));
          acc_y = add_sum(acc_y, spring(uy, e, d));
          acc_z = add_sum(acc_z, spring(uz, e, d));
        end
      end else if (r.interior) begin
        acc_x = add_sum(acc_x, pull(ux, pull_reg));
        acc_y = add_sum(acc_y, pull(uy, pull_reg));
        acc_z = add_sum(acc_z, pull(uz, pull_reg));
      end
    end
    if (r.last) begin
      c = stiff_reg > (64'sd1 << FRAC) ? (64'sd1 << FRAC) : stiff_reg;
      f.dx = scaled(acc_x, c);
      f.dy = scaled(acc_y, c);
      f.dz = scaled(acc_z, c);
      pending_forces = {pending_forces, f};
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
    end
  endtask

  // Called at a rising edge; returns at the edge of acceptance or after the gap.
  task automatic send_record(neighbor_rec_t r);
    int gap;
    in_valid <= 1;
    in_self_x <= r.sx; in_self_y <= r.sy; in_self_z <= r.sz;
    in_other_x <= r.ox; in_other_y <= r.oy; in_other_z <= r.oz;
    in_rest_length <= r.rest;
    in_self_knot <= r.sk; in_other_knot <= r.ok; in_self_interior <= r.interior;
    in_slot_valid <= r.live; in_last_slot <= r.last;
    do @(posedge clk); while (!in_ready);
    predict_force(r);
    records_sent++;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    if (idx == REG_STIFFNESS) stiff_reg = longint'($signed(val));
    else pull_reg = longint'($signed(val));
  endtask

  function automatic neighbor_rec_t make_rec(logic signed [POS_W-1:0] sx,
      logic signed [POS_W-1:0] ox, logic [REST_W-1:0] rest, bit sk, bit ok,
      bit interior, bit live, bit last);
    neighbor_rec_t r;
    r.sx = sx; r.sy = sx >>> 1; r.sz = -sx;
    r.ox = ox; r.oy = ox >>> 1; r.oz = -ox;
    r.rest = rest; r.sk = sk; r.ok = ok; r.interior = interior;
    r.live = live; r.last = last;
    return r;
  endfunction

  function automatic neighbor_rec_t random_rec(bit last);
    neighbor_rec_t r;
    int k;
    logic signed [POS_W-1:0] span;
    if ($urandom_range(0, 9) == 0) begin
      r.sx = $urandom; r.sy = $urandom; r.sz = $urandom;
      r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
      r.rest = REST_W'($urandom);
    end else begin
      k = $urandom_range(0, 22);
      span = 32'sd1 << k;
      r.sx = $urandom; r.sy = $urandom; r.sz = $urandom;
      r.ox = r.sx + $signed($urandom_range(0, 2 * span)) - span;
      r.oy = r.sy + $signed($urandom_range(0, 2 * span)) - span;
      r.oz = r.sz + $signed($urandom_range(0, 2 * span)) - span;
      r.rest = REST_W'($urandom_range(0, 3 * span));
    end
    r.sk = 1'($urandom_range(0, 1));
    r.ok = 1'($urandom_range(0, 1));
    r.interior = 1'($urandom_range(0, 1));
    r.live = $urandom_range(0, 9) != 0;
    r.last = last;
    return r;
  endfunction

  // Result side: random stall per transaction, then compare with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      forces_checked++;
      if (pending_forces.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h %h %h", $time,
                 out_delta_x, out_delta_y, out_delta_z);
      end else begin
        force_t f;
        f = pending_forces.pop_front();
        if (out_delta_x !== f.dx) begin
          errors++;
          $display("%0t: delta_x expected %h actual %h", $time, f.dx, out_delta_x);
        end
        if (out_delta_y !== f.dy) begin
          errors++;
          $display("%0t: delta_y expected %h actual %h", $time, f.dy, out_delta_y);
        end
        if (out_delta_z !== f.dz) begin
          errors++;
          $display("%0t: delta_z expected %h actual %h", $time, f.dz, out_delta_z);
        end
      end
      out_stall = no_gaps ? 0 : $urandom_range(0, 13);
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  task automatic test_directed();
    write_reg(REG_STIFFNESS, 32'h0001_0000);
    write_reg(REG_TRACTION, 32'h0000_8000);
    // Offset saturation, then the opposite corner, both knot springs.
    send_record(make_rec(32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff, 1, 1, 1, 1, 0));
    send_record(make_rec(32'sh7fff_ffff, 32'sh8000_0000, 31'h0, 1, 1, 0, 1, 1));
    // Zero distance in a spring case adds nothing and does not fall to traction.
    send_record(make_rec(32'sd1000, 32'sd1000, 31'd5, 1, 1, 1, 1, 1));
    send_record(make_rec(32'sd1000, 32'sd1000, 31'd5, 0, 0, 1, 1, 1));
    // Compressed neighbor, then stretched interior and stretched border.
    send_record(make_rec(32'sd0, 32'sd65536, 31'd400000, 0, 1, 0, 1, 0));
    send_record(make_rec(32'sd0, 32'sd900000, 31'd100, 0, 0, 1, 1, 0));
    send_record(make_rec(32'sd0, -32'sd900000, 31'd100, 1, 0, 0, 1, 1));
    // Invalid slot that closes a cell, and a lone tiny offset.
    send_record(make_rec(32'sd5, 32'sd9000, 31'd1, 0, 0, 1, 0, 1));
    send_record(make_rec(32'sd5, 32'sd6, 31'd0, 1, 1, 1, 1, 1));
    drain_and_settle();
    // Extreme gains drive the sums and outputs into saturation.
    write_reg(REG_TRACTION, 32'h7fff_ffff);
    write_reg(REG_STIFFNESS, 32'h7fff_ffff);
    repeat (4)
      send_record(make_rec(32'sh8000_0000, 32'sh7fff_ffff, 31'd0, 0, 0, 1, 1, 0));
    send_record(make_rec(32'sh8000_0000, 32'sh7fff_ffff, 31'd0, 0, 0, 1, 1, 1));
    drain_and_settle();
    write_reg(REG_TRACTION, 32'h8000_0000);
    write_reg(REG_STIFFNESS, 32'h8000_0000);
    send_record(make_rec(32'sh7fff_ffff, 32'sh8000_0000, 31'd0, 0, 0, 1, 1, 0));
    send_record(make_rec(32'sd0, 32'sd70000, 31'd0, 0, 0, 1, 1, 1));
    send_record(make_rec(32'sd3, -32'sd3, 31'h7fff_ffff, 0, 1, 1, 1, 1));
    drain_and_settle();
  endtask

  task automatic test_random_cells(int n_records, logic [POS_W-1:0] stiff,
                                   logic [POS_W-1:0] gain);
    int len;
    int sent;
    write_reg(REG_STIFFNESS, stiff);
    write_reg(REG_TRACTION, gain);
    sent = 0;
    while (sent < n_records) begin
      no_gaps = $urandom_range(0, 5) == 0;
      len = ($urandom_range(0, 19) == 0) ? 30 : $urandom_range(1, 5);
      for (int i = 0; i < len; i++) begin
        send_record(random_rec(i == len - 1));
        sent++;
      end
    end
    no_gaps = 0;
    drain_and_settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random_cells(100, 32'h0001_0000, 32'h0000_4000);
    test_random_cells(100, 32'h0000_0000, 32'h0001_0000);
    test_random_cells(100, 32'h7fff_ffff, 32'h8000_0000);
    test_random_cells(100, 32'h8000_0000, 32'h7fff_ffff);
    test_random_cells(100, $urandom, $urandom);
    test_random_cells(100, 32'hffff_8000, 32'h0000_0000);
    $display("Sent %0d neighbor records over nine register settings, checked %0d forces.",
             records_sent, forces_checked);
    $display("Covered saturation, knot springs, traction, dead slots and gain extremes.");
    if (errors == 0 && pending_forces.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Run timed out waiting for the block.");
    $display("status: fail");
    $finish;
  end

endmodule
